// ----- rtl/cubic_bezier_flattener_unit_assert.svh -----
// ---------------------------------------------------------------------------
// cubic bezier flattener assertion macros
// shared concurrent assertion forms for the flattener rtl
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_FLATTENER_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_FLATTENER_UNIT_ASSERT_SVH

// same-cycle implication
`define CBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbf assertion failed");

// next-cycle implication
`define CBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbf assertion failed");

`endif

// ----- rtl/cbf_pkg.sv -----
// ---------------------------------------------------------------------------
// cbf_pkg
// constants, kind codes and the bernstein weight table of the flattener
// ---------------------------------------------------------------------------
package cbf_pkg;

   localparam int NPTS      = 16;
   localparam int NSEG      = NPTS - 1;
   localparam int NINT      = NPTS - 2;
   localparam int PT_W      = (NINT > 1) ? $clog2(NINT) : 1;
   localparam int COORD_W   = 32;
   localparam int WGT_W     = 17;
   localparam int PROD_W    = COORD_W + WGT_W + 1;
   localparam int ACC_W     = PROD_W + 2;
   localparam int FRAC_W    = 16;
   localparam int Q_W       = ACC_W - FRAC_W;
   localparam longint unsigned BEZ_CUBE = longint'(NSEG) * NSEG * NSEG;

   localparam logic [1:0] KIND_CORNER = 2'd0;
   localparam logic [1:0] KIND_CTRL   = 2'd1;
   localparam logic [1:0] KIND_FINAL  = 2'd2;

   typedef logic [NINT-1:0][3:0][WGT_W-1:0] weight_table_type;

   function automatic weight_table_type build_weights();
      weight_table_type tbl;
      longint unsigned  num;
      longint unsigned  binom;
      tbl = '0;
      for (int i = 1; i <= NINT; i++) begin
         for (int k = 0; k < 4; k++) begin
            binom = (k == 0 || k == 3) ? 64'd1 : 64'd3;
            num   = binom;
            for (int j = 0; j < k; j++) begin
               num = num * longint'(i);
            end
            for (int j = k; j < 3; j++) begin
               num = num * longint'(NSEG - i);
            end
            tbl[i-1][k] = WGT_W'((num * 64'd65536 + BEZ_CUBE / 2) / BEZ_CUBE);
         end
      end
      return tbl;
   endfunction

   localparam weight_table_type WEIGHTS = build_weights();

endpackage

// ----- rtl/cubic_bezier_flattener_unit.sv -----
// ---------------------------------------------------------------------------
// cubic_bezier_flattener_unit
// flattens cubic bezier segments of a vertex stream into corner points
// ---------------------------------------------------------------------------
// usage:
//  req channel takes one vertex item (x, y, kind); rsp channel returns the
//  emitted vertices, run_last marks the last one caused by an input item.
//  a control item with fewer than two pending is stored and gives nothing.
//  a plain vertex passes through, after its one pending control point if
//  there is one; a curve-ending vertex gives NPTS-2 interior points, each
//  made in turn: one shared 32x17 multiplier runs four products per axis,
//  then one accumulate and one round/saturate step per axis, then one
//  output load.
//  req_stall is high while an item is being worked on; results sit in an
//  output register, so the next item is taken while the last result waits.
//  a stalled rsp holds the block in its emit step until the result leaves.
//  reset (synchronous, active high) clears anchor, pending control points
//  and the output valid. a final-kind item also returns the state to reset.
// ---------------------------------------------------------------------------
module cubic_bezier_flattener_unit
   import cbf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_x_coord,
   input  logic signed [COORD_W-1:0]  req_y_coord,
   input  logic        [1:0]          req_kind,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_W-1:0]  rsp_out_x,
   output logic signed [COORD_W-1:0]  rsp_out_y,
   output logic        [1:0]          rsp_out_kind,
   output logic                       rsp_run_last
);

`include "cubic_bezier_flattener_unit_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_RND,
      ST_EMIT_PT,
      ST_EMIT_CTRL,
      ST_EMIT_VTX
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                pending_ff, pending_in;
   logic signed [COORD_W-1:0] anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic signed [COORD_W-1:0] ctrl0_x_ff, ctrl0_x_in, ctrl0_y_ff, ctrl0_y_in;
   logic signed [COORD_W-1:0] ctrl1_x_ff, ctrl1_x_in, ctrl1_y_ff, ctrl1_y_in;
   logic signed [COORD_W-1:0] vtx_x_ff, vtx_x_in, vtx_y_ff, vtx_y_in;
   logic [1:0]                vtx_kind_ff, vtx_kind_in;
   logic [PT_W-1:0]           idx_ff, idx_in;
   logic [1:0]                term_ff, term_in;
   logic                      axis_ff, axis_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]                rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      load;
   logic signed [COORD_W-1:0] mul_op;
   logic [WGT_W-1:0]          mul_w;
   logic signed [ACC_W-1:0]   acc_sum;
   logic signed [ACC_W-1:0]   rnd_sum;
   logic [Q_W-1:0]            rnd_q;
   logic signed [COORD_W-1:0] sat_val;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign mul_w   = WEIGHTS[idx_ff][term_ff];
   assign acc_sum = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign rnd_sum = acc_ff + ACC_W'(1 << (FRAC_W - 1));
   assign rnd_q   = rnd_sum[ACC_W-1:FRAC_W];

   always_comb begin
      case (term_ff)
         2'd0:    mul_op = axis_ff ? anchor_y_ff : anchor_x_ff;
         2'd1:    mul_op = axis_ff ? ctrl0_y_ff  : ctrl0_x_ff;
         2'd2:    mul_op = axis_ff ? ctrl1_y_ff  : ctrl1_x_ff;
         default: mul_op = axis_ff ? vtx_y_ff    : vtx_x_ff;
      endcase
   end

   // round half up already folded in, clamp to 32-bit signed
   always_comb begin
      if (rnd_q[Q_W-1:COORD_W-1] == '0 || rnd_q[Q_W-1:COORD_W-1] == '1) begin
         sat_val = rnd_q[COORD_W-1:0];
      end else if (rnd_q[Q_W-1]) begin
         sat_val = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      anchor_x_in  = anchor_x_ff;
      anchor_y_in  = anchor_y_ff;
      ctrl0_x_in   = ctrl0_x_ff;
      ctrl0_y_in   = ctrl0_y_ff;
      ctrl1_x_in   = ctrl1_x_ff;
      ctrl1_y_in   = ctrl1_y_ff;
      vtx_x_in     = vtx_x_ff;
      vtx_y_in     = vtx_y_ff;
      vtx_kind_in  = vtx_kind_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vtx_x_in    = req_x_coord;
               vtx_y_in    = req_y_coord;
               vtx_kind_in = req_kind;
               if (req_kind == KIND_CTRL && pending_ff != 2'd2) begin
                  if (pending_ff == 2'd0) begin
                     ctrl0_x_in = req_x_coord;
                     ctrl0_y_in = req_y_coord;
                  end else begin
                     ctrl1_x_in = req_x_coord;
                     ctrl1_y_in = req_y_coord;
                  end
                  pending_in = pending_ff + 2'd1;
               end else if (pending_ff == 2'd2) begin
                  idx_in   = '0;
                  term_in  = 2'd0;
                  axis_in  = 1'b0;
                  state_in = ST_MUL;
               end else if (pending_ff == 2'd1) begin
                  state_in = ST_EMIT_CTRL;
               end else begin
                  state_in = ST_EMIT_VTX;
               end
            end
         end
         ST_MUL: begin
            prod_in = mul_op * $signed({1'b0, mul_w});
            acc_in  = (term_ff == 2'd0) ? '0 : acc_sum;
            if (term_ff == 2'd3) begin
               state_in = ST_ACC;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         ST_ACC: begin
            acc_in   = acc_sum;
            state_in = ST_RND;
         end
         ST_RND: begin
            if (!axis_ff) begin
               res_x_in = sat_val;
               axis_in  = 1'b1;
               term_in  = 2'd0;
               state_in = ST_MUL;
            end else begin
               res_y_in = sat_val;
               state_in = ST_EMIT_PT;
            end
         end
         ST_EMIT_PT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_kind_in  = KIND_CORNER;
               rsp_last_in  = 1'b0;
               if (idx_ff == PT_W'(NINT - 1)) begin
                  state_in = ST_EMIT_VTX;
               end else begin
                  idx_in   = idx_ff + PT_W'(1);
                  term_in  = 2'd0;
                  axis_in  = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_EMIT_CTRL: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = ctrl0_x_ff;
               rsp_y_in     = ctrl0_y_ff;
               rsp_kind_in  = KIND_CTRL;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT_VTX;
            end
         end
         ST_EMIT_VTX: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = vtx_x_ff;
               rsp_y_in     = vtx_y_ff;
               rsp_kind_in  = vtx_kind_ff;
               rsp_last_in  = 1'b1;
               pending_in   = 2'd0;
               anchor_x_in  = vtx_x_ff;
               anchor_y_in  = vtx_y_ff;
               if (vtx_kind_ff == KIND_FINAL) begin
                  anchor_x_in = '0;
                  anchor_y_in = '0;
                  ctrl0_x_in  = '0;
                  ctrl0_y_in  = '0;
                  ctrl1_x_in  = '0;
                  ctrl1_y_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 2'd0;
         anchor_x_ff  <= '0;
         anchor_y_ff  <= '0;
         ctrl0_x_ff   <= '0;
         ctrl0_y_ff   <= '0;
         ctrl1_x_ff   <= '0;
         ctrl1_y_ff   <= '0;
         idx_ff       <= '0;
         term_ff      <= 2'd0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         anchor_x_ff  <= anchor_x_in;
         anchor_y_ff  <= anchor_y_in;
         ctrl0_x_ff   <= ctrl0_x_in;
         ctrl0_y_ff   <= ctrl0_y_in;
         ctrl1_x_ff   <= ctrl1_x_in;
         ctrl1_y_ff   <= ctrl1_y_in;
         idx_ff       <= idx_in;
         term_ff      <= term_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vtx_x_ff    <= vtx_x_in;
      vtx_y_ff    <= vtx_y_in;
      vtx_kind_ff <= vtx_kind_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_run_last = rsp_last_ff;

   `CBF_ASSERT_NOW(a_pending_range, clock, reset, 1'b1, pending_ff != 2'd3)
   `CBF_ASSERT_NOW(a_acc_after_four, clock, reset, state_ff == ST_ACC, term_ff == 2'd3)
   `CBF_ASSERT_NEXT(a_interior_not_last, clock, reset, state_ff == ST_EMIT_PT && load,
                    rsp_valid_ff && !rsp_last_ff && rsp_kind_ff == KIND_CORNER)
   `CBF_ASSERT_NEXT(a_final_clears, clock, reset,
                    state_ff == ST_EMIT_VTX && load && vtx_kind_ff == KIND_FINAL,
                    anchor_x_ff == '0 && anchor_y_ff == '0 && pending_ff == 2'd0
                    && rsp_last_ff)

endmodule
